// ===== design/sfm_pkg.sv =====
// Shared types and constants for the symbol frequency model builder.
// Used by sfm_front, sfm_back and symbol_frequency_model_builder.
package sfm_pkg;

    localparam logic [31:0] CAP_RESET   = 32'd8192;
    localparam int          QUEUE_DEPTH = 4;
    localparam int          QPTR_W      = 2;
    localparam int          QCNT_W      = 3;

    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_COUNT  = 3'd1,
        CMD_LOAD   = 3'd2,
        CMD_FINAL  = 3'd3,
        CMD_LOOKUP = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_COUNT,
        OP_LOAD,
        OP_FINAL,
        OP_LOOKUP
    } op_kind_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [8:0]  symbol;
        logic [31:0] load_count;
    } in_t;

    typedef struct packed {
        logic [31:0] lower_bound;
        logic [31:0] upper_bound;
        logic [31:0] total_count;
        logic        was_sampled;
    } out_t;

    typedef struct packed {
        op_kind_t    kind;
        logic        hit;
        logic [8:0]  symbol;
        logic [31:0] load_count;
    } op_t;

    typedef struct packed {
        logic pop;
        logic init;
    } bk_status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_CNT_RD,
        S_CNT_WR,
        S_LOAD,
        S_FIN,
        S_FIN_EOM,
        S_LKP_RD,
        S_LKP_OUT
    } bk_state_t;

endpackage

// ===== design/sfm_front.sv =====
// Front end: command accept, classification and operation queue.
// Depends on sfm_pkg; feeds sfm_back.
module sfm_front
    import sfm_pkg::*;
#(
    parameter int NUM_SYMBOLS = 257
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  in_t        item,
    output logic       busy,
    input  bk_status_t status,
    output op_t        q_head,
    output logic       q_valid
);

    op_t                q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               full;
    logic               accept;
    logic               keep;
    logic               push;
    op_t                op_in;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign busy    = full || status.init;
    assign accept  = start && !busy;
    assign push    = accept && keep;
    assign q_valid = (count_reg != '0);
    assign q_head  = q_mem[rd_ptr_reg];

    always_comb
    begin
        keep             = 1'b0;
        op_in.kind       = OP_CLEAR;
        op_in.hit        = (32'(item.symbol) < 32'(NUM_SYMBOLS));
        op_in.symbol     = item.symbol;
        op_in.load_count = item.load_count;
        case (item.cmd)
            CMD_CLEAR:
            begin
                keep       = 1'b1;
                op_in.kind = OP_CLEAR;
            end
            CMD_COUNT:
            begin
                keep       = (32'(item.symbol) < 32'(NUM_SYMBOLS - 1));
                op_in.kind = OP_COUNT;
            end
            CMD_LOAD:
            begin
                keep       = (32'(item.symbol) < 32'(NUM_SYMBOLS - 1));
                op_in.kind = OP_LOAD;
            end
            CMD_FINAL:
            begin
                keep       = 1'b1;
                op_in.kind = OP_FINAL;
            end
            CMD_LOOKUP:
            begin
                keep       = 1'b1;
                op_in.kind = OP_LOOKUP;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = status.pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !status.pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!push && status.pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= op_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        status.pop |-> q_valid)
        else $error("pop from empty queue");

    a_no_accept_init: assert property (@(posedge clk) disable iff (!rst_n)
        status.init |-> !push)
        else $error("transfer during init sweep");

endmodule

// ===== design/sfm_back.sv =====
// Back end: count table, cumulative table, finalize walk and lookups.
// Depends on sfm_pkg; takes operations from sfm_front.
module sfm_back
    import sfm_pkg::*;
#(
    parameter int NUM_SYMBOLS = 257,
    parameter int COUNT_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] frequency_cap,
    input  op_t         q_head,
    input  logic        q_valid,
    output bk_status_t  status,
    output logic        result_valid,
    output out_t        result
);

    localparam int NB    = NUM_SYMBOLS - 1;
    localparam int SYM_W = $clog2(NUM_SYMBOLS);
    localparam int CA    = (NB > 1) ? $clog2(NB) : 1;
    localparam int CW    = COUNT_WIDTH;

    logic [CW-1:0]   cnt_mem [NB];
    logic [2*CW-1:0] cum_mem [NUM_SYMBOLS];

    bk_state_t        state_reg, state_next;
    logic [SYM_W-1:0] ptr_reg, ptr_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [SYM_W-1:0] pend_idx_reg, pend_idx_next;
    logic [CW-1:0]    run_reg, run_next;
    logic [CW-1:0]    grand_reg, grand_next;
    logic [31:0]      bytes_reg, bytes_next;
    logic             sampled_reg, sampled_next;
    op_t              op_reg, op_next;
    logic             result_valid_reg, result_valid_next;
    out_t             result_reg, result_next;

    logic [CW-1:0]    cnt_rdata_reg;
    logic [2*CW-1:0]  cum_rdata_reg;

    logic             pop;
    logic             cnt_we;
    logic [CA-1:0]    cnt_waddr, cnt_raddr;
    logic [CW-1:0]    cnt_wdata;
    logic             cum_we;
    logic [SYM_W-1:0] cum_waddr, cum_raddr;
    logic [2*CW-1:0]  cum_wdata;

    logic [CA-1:0]    ptr_cnt, pend_cnt, op_cnt;
    logic [SYM_W-1:0] op_sym;
    logic             fin_fill;
    logic [CW-1:0]    eff_cnt;
    logic [CW-1:0]    fin_sum;
    logic [CW-1:0]    eom_sum;
    logic [31:0]      bytes_inc;
    logic             issue;

    assign ptr_cnt   = ptr_reg[CA-1:0];
    assign pend_cnt  = pend_idx_reg[CA-1:0];
    assign op_cnt    = CA'(op_reg.symbol);
    assign op_sym    = SYM_W'(op_reg.symbol);
    assign fin_fill  = sampled_reg && (cnt_rdata_reg == '0);
    assign eff_cnt   = fin_fill ? CW'(1) : cnt_rdata_reg;
    assign fin_sum   = run_reg + eff_cnt;
    assign eom_sum   = run_reg + CW'(1);
    assign bytes_inc = bytes_reg + 32'd1;
    assign issue     = (32'(ptr_reg) < 32'(NB));

    assign status.pop   = pop;
    assign status.init  = (state_reg == S_INIT);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                if (ptr_reg == SYM_W'(NUM_SYMBOLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_head.kind)
                        OP_CLEAR:  state_next = S_CLEAR;
                        OP_COUNT:  state_next = S_CNT_RD;
                        OP_LOAD:   state_next = S_LOAD;
                        OP_FINAL:  state_next = S_FIN;
                        OP_LOOKUP: state_next = S_LKP_RD;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_CNT_RD:
            begin
                state_next = sampled_reg ? S_IDLE : S_CNT_WR;
            end
            S_FIN:
            begin
                if (pend_valid_reg && pend_idx_reg == SYM_W'(NB - 1))
                begin
                    state_next = S_FIN_EOM;
                end
            end
            S_LKP_RD:
            begin
                state_next = S_LKP_OUT;
            end
            S_CNT_WR, S_LOAD, S_FIN_EOM, S_LKP_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop               = 1'b0;
        cnt_we            = 1'b0;
        cnt_waddr         = ptr_cnt;
        cnt_wdata         = '0;
        cnt_raddr         = ptr_cnt;
        cum_we            = 1'b0;
        cum_waddr         = ptr_reg;
        cum_wdata         = '0;
        cum_raddr         = op_sym;
        ptr_next          = ptr_reg;
        pend_valid_next   = 1'b0;
        pend_idx_next     = ptr_reg;
        run_next          = run_reg;
        grand_next        = grand_reg;
        bytes_next        = bytes_reg;
        sampled_next      = sampled_reg;
        op_next           = op_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                cnt_we   = issue;
                cum_we   = 1'b1;
                ptr_next = (ptr_reg == SYM_W'(NUM_SYMBOLS - 1)) ? '0 : ptr_reg + SYM_W'(1);
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop      = 1'b1;
                    op_next  = q_head;
                    ptr_next = '0;
                    case (q_head.kind)
                        OP_CLEAR:
                        begin
                            bytes_next   = '0;
                            sampled_next = 1'b0;
                            grand_next   = '0;
                        end
                        OP_FINAL:
                        begin
                            run_next = '0;
                        end
                        default:
                        begin
                            run_next = run_reg;
                        end
                    endcase
                end
            end
            S_CNT_RD:
            begin
                cnt_raddr = op_cnt;
            end
            S_CNT_WR:
            begin
                cnt_we     = 1'b1;
                cnt_waddr  = op_cnt;
                cnt_wdata  = cnt_rdata_reg + CW'(1);
                bytes_next = bytes_inc;
                if (bytes_inc >= frequency_cap)
                begin
                    sampled_next = 1'b1;
                end
            end
            S_LOAD:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = op_cnt;
                cnt_wdata = CW'(op_reg.load_count);
            end
            S_FIN:
            begin
                if (issue)
                begin
                    ptr_next = ptr_reg + SYM_W'(1);
                end
                pend_valid_next = issue;
                pend_idx_next   = ptr_reg;
                if (pend_valid_reg)
                begin
                    cnt_we    = fin_fill;
                    cnt_waddr = pend_cnt;
                    cnt_wdata = CW'(1);
                    cum_we    = 1'b1;
                    cum_waddr = pend_idx_reg;
                    cum_wdata = {run_reg, fin_sum};
                    run_next  = fin_sum;
                end
            end
            S_FIN_EOM:
            begin
                cum_we                  = 1'b1;
                cum_waddr               = SYM_W'(NB);
                cum_wdata               = {run_reg, eom_sum};
                grand_next              = eom_sum;
                result_valid_next       = 1'b1;
                result_next.lower_bound = '0;
                result_next.upper_bound = '0;
                result_next.total_count = 32'(eom_sum);
                result_next.was_sampled = sampled_reg;
            end
            S_LKP_OUT:
            begin
                result_valid_next       = 1'b1;
                result_next.lower_bound = op_reg.hit ? 32'(cum_rdata_reg[2*CW-1:CW]) : '0;
                result_next.upper_bound = op_reg.hit ? 32'(cum_rdata_reg[CW-1:0]) : '0;
                result_next.total_count = 32'(grand_reg);
                result_next.was_sampled = sampled_reg;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata_reg <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cum_we)
        begin
            cum_mem[cum_waddr] <= cum_wdata;
        end
        cum_rdata_reg <= cum_mem[cum_raddr];
    end

    always_ff @(posedge clk)
    begin
        run_reg     <= run_next;
        op_reg      <= op_next;
        result_reg  <= result_next;
        pend_idx_reg <= pend_idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_INIT;
            ptr_reg          <= '0;
            pend_valid_reg   <= 1'b0;
            grand_reg        <= '0;
            bytes_reg        <= '0;
            sampled_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            ptr_reg          <= ptr_next;
            pend_valid_reg   <= pend_valid_next;
            grand_reg        <= grand_next;
            bytes_reg        <= bytes_next;
            sampled_reg      <= sampled_next;
            result_valid_reg <= result_valid_next;
        end
    end

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> ($past(state_reg) == S_FIN_EOM || $past(state_reg) == S_LKP_OUT))
        else $error("result transfer without finalize or lookup");

    a_sampled_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (sampled_reg && !pop) |=> $stable(bytes_reg))
        else $error("byte total moved after sampling");

    a_fin_fill_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && cnt_we) |-> (cnt_wdata == CW'(1) && sampled_reg))
        else $error("bad fill write during finalize");

    a_fin_zero_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN_EOM) |=> (result_reg.lower_bound == '0 &&
                                      result_reg.upper_bound == '0))
        else $error("finalize result with nonzero bounds");

endmodule

// ===== design/symbol_frequency_model_builder.sv =====
// Channel    | Signals                        | Transfer
// -----------+--------------------------------+------------------------------
// command    | start, busy, item (in_t)       | start && !busy at clk rise
// result     | result_valid, result (out_t)   | one cycle while result_valid
// config     | cap_we, cap_wdata              | cap_we at clk rise
//
// Commands go into a 4-entry queue; busy is high while it is full.
// Back end timing is set by registered table reads and by one-entry-per-cycle walks
// over the tables for clear and finalize.
// After reset a sweep zeroes both tables; busy holds high.
// Results appear one cycle each and cannot be stalled.
module symbol_frequency_model_builder
    import sfm_pkg::*;
#(
    parameter int NUM_SYMBOLS = 257,
    parameter int COUNT_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  in_t         item,
    output logic        busy,
    output logic        result_valid,
    output out_t        result,
    input  logic        cap_we,
    input  logic [31:0] cap_wdata
);

    logic [31:0] cap_reg, cap_next;
    op_t         q_head;
    logic        q_valid;
    bk_status_t  status;

    assign cap_next = cap_we ? cap_wdata : cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    sfm_front #(
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .item    (item),
        .busy    (busy),
        .status  (status),
        .q_head  (q_head),
        .q_valid (q_valid)
    );

    sfm_back #(
        .NUM_SYMBOLS (NUM_SYMBOLS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .frequency_cap (cap_reg),
        .q_head        (q_head),
        .q_valid       (q_valid),
        .status        (status),
        .result_valid  (result_valid),
        .result        (result)
    );

endmodule

// ===== verif/sfm_model_checker.sv =====
// Checker for symbol_frequency_model_builder: predicts the count table, bounds and totals
// from the observed command and config transfers and compares each result transfer.
// Depends on sfm_pkg for in_t, out_t, cmd_t and CAP_RESET.
module sfm_model_checker
    import sfm_pkg::*;
#(
    parameter int NUM_SYMBOLS = 257
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  in_t         item,
    input  logic        result_valid,
    input  out_t        result,
    input  logic        cap_we,
    input  logic [31:0] cap_wdata,
    output int          outstanding,
    output int          fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EOM        = NUM_SYMBOLS - 1;
    localparam int REPORT_MAX = 10;

    logic [31:0] cap;
    logic [31:0] count_tbl [NUM_SYMBOLS];
    logic [31:0] upper_tbl [NUM_SYMBOLS];
    logic [31:0] bytes_seen;
    logic        sampled;
    logic [31:0] grand_total;
    out_t        bounds_q [$];
    out_t        want;
    out_t        pred;
    int          mismatches = 0;

    assign fail_count = mismatches;

    function automatic void clear_model();
        for (int i = 0; i < NUM_SYMBOLS; i++)
        begin
            count_tbl[i] = '0;
            upper_tbl[i] = '0;
        end
        count_tbl[EOM] = 32'd1;
        bytes_seen     = '0;
        sampled        = 1'b0;
        grand_total    = '0;
    endfunction

    function automatic void build_bounds();
        logic [31:0] run;
        run = '0;
        if (sampled)
        begin
            for (int i = 0; i < EOM; i++)
                if (count_tbl[i] == '0)
                    count_tbl[i] = 32'd1;
        end
        for (int i = 0; i < NUM_SYMBOLS; i++)
        begin
            run          = run + count_tbl[i];
            upper_tbl[i] = run;
        end
        grand_total = run;
    endfunction

    // returns 1 when the command produces a result
    function automatic bit apply_cmd(input in_t it, output out_t res);
        res = '0;
        case (it.cmd)
            CMD_CLEAR:
            begin
                clear_model();
                return 1'b0;
            end
            CMD_COUNT:
            begin
                if (!sampled && it.symbol < EOM)
                begin
                    count_tbl[it.symbol] = count_tbl[it.symbol] + 32'd1;
                    bytes_seen           = bytes_seen + 32'd1;
                    if (bytes_seen >= cap)
                        sampled = 1'b1;
                end
                return 1'b0;
            end
            CMD_LOAD:
            begin
                if (it.symbol < EOM)
                    count_tbl[it.symbol] = it.load_count;
                return 1'b0;
            end
            CMD_FINAL:
                build_bounds();
            CMD_LOOKUP:
            begin
                if (it.symbol < NUM_SYMBOLS)
                begin
                    res.upper_bound = upper_tbl[it.symbol];
                    res.lower_bound = (it.symbol == 0) ? '0 : upper_tbl[it.symbol - 1];
                end
            end
            default:
                return 1'b0;
        endcase
        res.total_count = grand_total;
        res.was_sampled = sampled;
        return 1'b1;
    endfunction

    function automatic void flag_mismatch(input string what, input out_t exp_r, input out_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%t sfm %s: exp lo=%h hi=%h tot=%h smp=%b got lo=%h hi=%h tot=%h smp=%b",
                     $realtime, what, exp_r.lower_bound, exp_r.upper_bound, exp_r.total_count,
                     exp_r.was_sampled, got.lower_bound, got.upper_bound, got.total_count,
                     got.was_sampled);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap = CAP_RESET;
            clear_model();
            bounds_q.delete();
            outstanding <= 0;
        end
        else
        begin
            // results left the block before any command accepted this edge
            if (result_valid)
            begin
                if (bounds_q.size() == 0)
                    flag_mismatch("unexpected result", '0, result);
                else
                begin
                    want = bounds_q.pop_front();
                    if (want.lower_bound !== result.lower_bound
                        || want.upper_bound !== result.upper_bound
                        || want.total_count !== result.total_count
                        || want.was_sampled !== result.was_sampled)
                        flag_mismatch("result mismatch", want, result);
                end
            end
            if (cap_we)
                cap = cap_wdata;
            if (start && !busy && apply_cmd(item, pred))
                bounds_q.push_back(pred);
            outstanding <= bounds_q.size();
        end
    end

endmodule

// ===== verif/tb_symbol_frequency_model_builder.sv =====
// Top testbench for symbol_frequency_model_builder: directed and random command
// transfers over several cap settings, checked by sfm_model_checker.
// Depends on sfm_pkg, sfm_model_checker and the block itself.
module tb_symbol_frequency_model_builder;
    import sfm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SYMBOLS = 257;
    localparam int EOM         = NUM_SYMBOLS - 1;
    localparam int SYM_MAX     = 511;
    localparam int SETTLE      = 6 * (NUM_SYMBOLS + 3);
    localparam int CYCLE_LIMIT = 1500000;
    localparam int ITEM_TARGET = 1100;
    localparam int N_PHASES    = 8;
    localparam int LOWERED_CAP_PHASE = 4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    in_t         item = '0;
    logic        busy;
    logic        result_valid;
    out_t        result;
    logic        cap_we = 1'b0;
    logic [31:0] cap_wdata = '0;
    int          outstanding;
    int          fail_count;
    int          cycles = 0;
    int          items_sent = 0;
    int          max_gap = 6;

    always #2 clk = ~clk;

    symbol_frequency_model_builder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .cap_we       (cap_we),
        .cap_wdata    (cap_wdata)
    );

    sfm_model_checker #(.NUM_SYMBOLS(NUM_SYMBOLS)) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cap_we       (cap_we),
        .cap_wdata    (cap_wdata),
        .outstanding  (outstanding),
        .fail_count   (fail_count)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_symbol_frequency_model_builder: done, errors");
            $finish;
        end
    end

    // one command transfer, preceded by a random idle gap
    task automatic send_cmd(input cmd_t c, input logic [8:0] s, input logic [31:0] v);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start           <= 1'b1;
        item.cmd        <= c;
        item.symbol     <= s;
        item.load_count <= v;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cap(input logic [31:0] v);
        wait_idle();
        cap_we    <= 1'b1;
        cap_wdata <= v;
        @(posedge clk);
        cap_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_load();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return $urandom_range(1, 20);
            2:       return $urandom();
            3:       return '1;
            default: return $urandom_range(0, 1000);
        endcase
    endfunction

    function automatic logic [8:0] pick_byte();
        if ($urandom_range(0, 1) == 0)
            return 9'($urandom_range(0, 15));
        return 9'($urandom_range(0, EOM - 1));
    endfunction

    function automatic logic [8:0] pick_lookup_sym();
        if ($urandom_range(0, 9) == 0)
            return 9'($urandom_range(NUM_SYMBOLS, SYM_MAX));
        return 9'($urandom_range(0, EOM));
    endfunction

    // optionally clear, count bytes with sprinkled loads and noise, finalize, then look up bounds
    task automatic run_message(input bit do_clear);
        int n_bytes;
        int n_lookups;
        int roll;
        n_bytes   = $urandom_range(4, 90);
        n_lookups = $urandom_range(3, 16);
        max_gap   = ($urandom_range(0, 3) == 0) ? 0 : 6;
        if (do_clear)
            send_cmd(CMD_CLEAR, 9'($urandom_range(0, SYM_MAX)), $urandom());
        for (int i = 0; i < n_bytes; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                send_cmd(cmd_t'($urandom_range(0, 7)), 9'($urandom_range(0, SYM_MAX)),
                         $urandom());
            else if (roll < 7)
                send_cmd(cmd_t'(CMD_LOOKUP + $urandom_range(1, 3)),
                         9'($urandom_range(0, SYM_MAX)), $urandom());
            else if (roll < 10)
                send_cmd($urandom_range(0, 1) ? CMD_COUNT : CMD_LOAD,
                         9'($urandom_range(EOM, SYM_MAX)), pick_load());
            else if (roll < 20)
                send_cmd(CMD_LOAD, pick_byte(), pick_load());
            else
                send_cmd(CMD_COUNT, pick_byte(), $urandom());
        end
        send_cmd(CMD_FINAL, 9'($urandom_range(0, SYM_MAX)), $urandom());
        for (int i = 0; i < n_lookups; i++)
            send_cmd(CMD_LOOKUP, pick_lookup_sym(), $urandom());
    endtask

    initial
    begin
        logic [31:0] caps [N_PHASES];
        int          phase_end;
        caps = '{32'd1, 32'd3, 32'd40, 32'hFFFF_FFFF, 32'd2, CAP_RESET, 32'd100, 32'd17};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset cap, empty table, end symbol, wraps, unused commands
        max_gap = 2;
        send_cmd(CMD_LOOKUP, 9'd0, '0);
        send_cmd(CMD_LOOKUP, 9'(EOM), '0);
        send_cmd(CMD_LOOKUP, 9'(SYM_MAX), '1);
        send_cmd(CMD_FINAL, 9'd0, '0);
        send_cmd(CMD_LOOKUP, 9'(EOM), '0);
        send_cmd(CMD_COUNT, 9'd0, '1);
        send_cmd(CMD_COUNT, 9'(EOM - 1), '0);
        send_cmd(CMD_COUNT, 9'(EOM), '0);
        send_cmd(CMD_COUNT, 9'(SYM_MAX), '0);
        send_cmd(CMD_LOAD, 9'(EOM - 1), '1);
        send_cmd(CMD_LOAD, 9'(EOM), 32'd7);
        send_cmd(CMD_LOAD, 9'(SYM_MAX), 32'hA5A5_5A5A);
        send_cmd(CMD_COUNT, 9'(EOM - 1), '0);
        send_cmd(CMD_LOAD, 9'd1, '1);
        send_cmd(CMD_FINAL, 9'(SYM_MAX), '1);
        send_cmd(CMD_LOOKUP, 9'd0, '0);
        send_cmd(CMD_LOOKUP, 9'd1, '0);
        send_cmd(CMD_LOOKUP, 9'(EOM - 1), '0);
        send_cmd(CMD_LOOKUP, 9'(EOM), '0);
        send_cmd(CMD_LOOKUP, 9'(NUM_SYMBOLS), '0);
        send_cmd(cmd_t'(CMD_LOOKUP + 1), 9'(SYM_MAX), '1);
        send_cmd(cmd_t'(CMD_LOOKUP + 2), 9'd0, '0);
        send_cmd(cmd_t'(CMD_LOOKUP + 3), 9'd1, 32'h5555_5555);
        send_cmd(CMD_CLEAR, 9'(SYM_MAX), '1);
        send_cmd(CMD_LOOKUP, 9'd1, '0);

        // phase after the all-ones cap keeps its table to see a cap lowered under the total
        for (int p = 0; p < N_PHASES; p++)
        begin
            write_cap(caps[p]);
            phase_end = items_sent + (ITEM_TARGET - items_sent) / (N_PHASES - p);
            run_message(p != LOWERED_CAP_PHASE);
            while (items_sent < phase_end)
                run_message($urandom_range(0, 3) != 0);
        end

        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("tb_symbol_frequency_model_builder: done, clean");
        else
            $display("tb_symbol_frequency_model_builder: done, errors");
        $finish;
    end

endmodule
